[design/sorted_unique_address_set_core_macros.svh]
// assertion macros for the sorted unique address set core
// used by the checker file, no other dependencies
`ifndef SORTED_UNIQUE_ADDRESS_SET_CORE_MACROS_SVH
`define SORTED_UNIQUE_ADDRESS_SET_CORE_MACROS_SVH

// same-cycle implication
`define SUAS_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SUAS_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

[design/suas_pkg.sv]
// shared types and constants for the sorted unique address set core
// no dependencies
`default_nettype none

package suas_pkg;

   localparam int CAPACITY = 128;
   localparam int ADDR_W   = 64;
   localparam int INDEX_W  = 7;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int TOTAL_W  = 8;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_FULL     = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_RANGE    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_APPLY
   } state_type;

   // control broadcast to every cell
   typedef struct packed {
      logic search;
      logic ins_shift;
      logic rem_shift;
   } cell_ctl_type;

endpackage

`default_nettype wire

[design/suas_cell.sv]
// one storage cell of the sorted chain: entry, compare flags, shift
// depends on suas_pkg
`default_nettype none

module suas_cell (
   input  wire                          clock,
   input  wire suas_pkg::cell_ctl_type  ctl,
   input  wire [suas_pkg::ADDR_W-1:0]   key,
   input  wire [suas_pkg::INDEX_W-1:0]  index,
   input  wire [suas_pkg::IDX_W-1:0]    position,
   input  wire                          occupied,
   input  wire                          left_lt,
   input  wire [suas_pkg::ADDR_W-1:0]   left_entry,
   input  wire [suas_pkg::ADDR_W-1:0]   right_entry,
   output logic [suas_pkg::ADDR_W-1:0]  entry,
   output logic                         lt,
   output logic                         eq,
   output logic                         rd_hit
);

   logic [suas_pkg::ADDR_W-1:0] entry_ff, entry_in;
   logic lt_ff, eq_ff, rd_hit_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins_shift && !lt_ff) begin
         // this cell and everything above moves up, the first one takes the key
         entry_in = left_lt ? key : left_entry;
      end else if (ctl.rem_shift && !lt_ff) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (ctl.search) begin
         lt_ff     <= occupied && (entry_ff < key);
         eq_ff     <= occupied && (entry_ff == key);
         rd_hit_ff <= occupied &&
                      (suas_pkg::CMP_W'(position) == suas_pkg::CMP_W'(index));
      end
   end

   assign entry  = entry_ff;
   assign lt     = lt_ff;
   assign eq     = eq_ff;
   assign rd_hit = rd_hit_ff;

endmodule

`default_nettype wire

[design/suas_ctrl.sv]
// sequencer for the cell chain: state, entry count and result status
// depends on suas_pkg
`default_nettype none

module suas_ctrl (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_fire,
   input  wire                            out_free,
   input  wire [suas_pkg::OP_W-1:0]       op,
   input  wire                            key_zero,
   input  wire                            any_eq,
   input  wire                            any_rd,
   output logic                           ready,
   output logic                           commit,
   output suas_pkg::cell_ctl_type         cell_ctl,
   output suas_pkg::status_type           status,
   output logic [suas_pkg::CNT_W-1:0]     count,
   output logic [suas_pkg::CNT_W-1:0]     count_next
);

   suas_pkg::state_type state_ff, state_in;
   logic [suas_pkg::CNT_W-1:0] count_ff;
   logic full;

   assign full = (count_ff == suas_pkg::CNT_W'(suas_pkg::CAPACITY));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         suas_pkg::S_IDLE:   if (req_fire) state_in = suas_pkg::S_SEARCH;
         suas_pkg::S_SEARCH: state_in = suas_pkg::S_APPLY;
         suas_pkg::S_APPLY:  if (out_free) state_in = suas_pkg::S_IDLE;
         default:            state_in = suas_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      ready              = (state_ff == suas_pkg::S_IDLE);
      commit             = (state_ff == suas_pkg::S_APPLY) && out_free;
      cell_ctl.search    = (state_ff == suas_pkg::S_SEARCH);
      cell_ctl.ins_shift = 1'b0;
      cell_ctl.rem_shift = 1'b0;
      status             = suas_pkg::ST_OK;
      count_next         = count_ff;
      case (op)
         suas_pkg::OP_INSERT: begin
            if (key_zero) begin
               status = suas_pkg::ST_OK;
            end else if (any_eq) begin
               status = suas_pkg::ST_DUP;
            end else if (full) begin
               status = suas_pkg::ST_FULL;
            end else begin
               cell_ctl.ins_shift = commit;
               count_next         = count_ff + suas_pkg::CNT_W'(1);
            end
         end
         suas_pkg::OP_REMOVE: begin
            if (key_zero || !any_eq) begin
               status = suas_pkg::ST_NOTFOUND;
            end else begin
               cell_ctl.rem_shift = commit;
               count_next         = count_ff - suas_pkg::CNT_W'(1);
            end
         end
         suas_pkg::OP_READ: begin
            if (!any_rd) status = suas_pkg::ST_RANGE;
         end
         default: status = suas_pkg::ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= suas_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (commit) count_ff <= count_next;
      end
   end

   assign count = count_ff;

endmodule

`default_nettype wire

[design/sorted_unique_address_set_core.sv]
// top level of the sorted unique address set core
// depends on suas_pkg, suas_cell and suas_ctrl
//
// keeps up to CAPACITY nonzero 64-bit addresses in ascending order, no duplicates
// req channel: one beat is one command (insert, remove or read at index)
// rsp channel: exactly one beat per command with status, entry total and read value
// storage is a row of cells; cell i holds the i-th smallest address, cells at or
// above the entry count hold nothing meaningful and are never read
// each command goes through the accept cycle, a search cycle in which every
// cell compares its entry against the key in parallel and registers the result,
// and an apply cycle in which every cell at or above the insert or remove point
// takes its neighbor's entry (or the key) and the result beat is loaded
// the result beat is registered at the end of the apply step, and rsp_tvalid rises with it
// a new command is accepted only after the previous one has left the apply step
// req_tready is high only while no command is in the chain
// when the receiver stalls, the result beat holds in the output register; the next
// command is still accepted and searched, and its apply step waits until the
// output register is drained
// reset clears the entry count and the control state; stored entries are not cleared
`default_nettype none

module sorted_unique_address_set_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [71:0] req_tdata,   // [63:0] address, [70:64] index, [71] zero
   input  wire  [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,   // [7:0] entry_total, [71:8] read_value
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   // command registers, loaded on an accepted beat
   logic [suas_pkg::ADDR_W-1:0]  key_ff;
   logic [suas_pkg::INDEX_W-1:0] index_ff;
   logic [suas_pkg::OP_W-1:0]    op_ff;

   // result beat
   logic                          rsp_valid_ff;
   logic [suas_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [suas_pkg::TOTAL_W-1:0]  rsp_total_ff;
   logic [suas_pkg::ADDR_W-1:0]   rsp_value_ff;

   logic req_fire, out_free, commit, ready;
   suas_pkg::cell_ctl_type      cell_ctl;
   suas_pkg::status_type        status;
   logic [suas_pkg::CNT_W-1:0]  count, count_next;

   // chain taps
   logic [suas_pkg::ADDR_W-1:0] entry_w [suas_pkg::CAPACITY];
   logic [suas_pkg::CAPACITY-1:0] lt_w, eq_w, hit_w;
   logic [suas_pkg::ADDR_W-1:0] read_value;

   assign req_fire = req_tvalid && ready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         key_ff   <= req_tdata[suas_pkg::ADDR_W-1:0];
         index_ff <= req_tdata[suas_pkg::ADDR_W +: suas_pkg::INDEX_W];
         op_ff    <= req_tuser;
      end
   end

   suas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .out_free   (out_free),
      .op         (op_ff),
      .key_zero   (key_ff == '0),
      .any_eq     (|eq_w),
      .any_rd     (|hit_w),
      .ready      (ready),
      .commit     (commit),
      .cell_ctl   (cell_ctl),
      .status     (status),
      .count      (count),
      .count_next (count_next)
   );

   // row of cells, neighbors wired left (smaller) and right (larger)
   for (genvar i = 0; i < suas_pkg::CAPACITY; i++) begin : g_cell
      logic                        left_lt;
      logic [suas_pkg::ADDR_W-1:0] left_entry, right_entry;

      if (i == 0) begin : g_first
         assign left_lt    = 1'b1;
         assign left_entry = key_ff;
      end else begin : g_inner
         assign left_lt    = lt_w[i-1];
         assign left_entry = entry_w[i-1];
      end

      if (i == suas_pkg::CAPACITY - 1) begin : g_last
         assign right_entry = entry_w[i];
      end else begin : g_body
         assign right_entry = entry_w[i+1];
      end

      suas_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .key         (key_ff),
         .index       (index_ff),
         .position    (suas_pkg::IDX_W'(i)),
         .occupied    (suas_pkg::CNT_W'(i) < count),
         .left_lt     (left_lt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entry_w[i]),
         .lt          (lt_w[i]),
         .eq          (eq_w[i]),
         .rd_hit      (hit_w[i])
      );
   end

   // at most one cell flags a read hit, so an and-or picks its entry
   always_comb begin
      read_value = '0;
      for (int i = 0; i < suas_pkg::CAPACITY; i++) begin
         read_value = read_value | (hit_w[i] ? entry_w[i] : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff <= status;
         rsp_total_ff  <= suas_pkg::TOTAL_W'(count_next);
         rsp_value_ff  <= (op_ff == suas_pkg::OP_READ) ? read_value : '0;
      end
   end

   assign req_tready = ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_value_ff, rsp_total_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

[design/suas_checker.sv]
// port-level checker for the sorted unique address set core, with its bind
// depends on suas_pkg and sorted_unique_address_set_core_macros.svh
`default_nettype none

`include "sorted_unique_address_set_core_macros.svh"

module suas_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [71:0] rsp_tdata,
   input wire [2:0]  rsp_tuser
);

   // a stalled result beat holds
   `SUAS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled rsp beat changed")

   // no result beat right after reset
   `SUAS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "rsp valid after reset")

   // an accepted command keeps the block busy for the next cycle
   `SUAS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "req ready right after accept")

   // read value is zero unless the status is ok
   `SUAS_ASSERT_NOW(a_value_zero, clock, reset, rsp_tvalid && (rsp_tuser != suas_pkg::ST_OK), rsp_tdata[71:8] == 64'd0, "nonzero read value with error status")

endmodule

bind sorted_unique_address_set_core suas_checker u_suas_checker (.*);

`default_nettype wire

[test/testbench.sv]
// self-checking bench for sorted_unique_address_set_core: insert, remove and read beats
// against an in-bench model of the sorted set, with random stalls on both streams
// depends on suas_pkg and the core rtl
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import suas_pkg::*;

   // op 3 has no function and must leave the set alone
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 2000;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [ADDR_W-1:0]  address;
      logic [INDEX_W-1:0] index;
   } command_type;

   typedef struct packed {
      status_type         status;
      logic [TOTAL_W-1:0] total;
      logic [ADDR_W-1:0]  value;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // [63:0] address, [70:64] index, [71] zero
   logic [1:0]  req_tuser = '0;   // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // [7:0] entry_total, [71:8] read_value
   logic [2:0]  rsp_tuser;        // [2:0] status

   // model of the stored set
   logic [ADDR_W-1:0] set_entries [CAPACITY];
   int                set_count = 0;

   command_type  command_backlog [$];
   result_type   pending_results [$];
   logic [63:0]  address_pool [$];
   command_type  driven_cmd;
   result_type   want_rsp;
   int           sent_count = 0;
   int           accept_count = 0;
   int           cycle_nr = 0;
   int           mismatch_count = 0;
   logic         quiet;

   sorted_unique_address_set_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // stretch with no idling on either stream
   assign quiet = (cycle_nr >= 2000) && (cycle_nr < 5000);

   // applies one command to the model set and returns the result beat it yields
   function automatic result_type apply_to_set(command_type c);
      int         pos;
      int         i;
      result_type r;
      r.status = ST_OK;
      r.value  = '0;
      pos = 0;
      if (c.op == OP_INSERT || c.op == OP_REMOVE) begin
         while (pos < set_count && set_entries[pos] < c.address) pos++;
      end
      if (c.op == OP_INSERT) begin
         if (c.address == '0) begin
            r.status = ST_OK;   // zero is never stored
         end else if (pos < set_count && set_entries[pos] == c.address) begin
            r.status = ST_DUP;  // duplicate wins over full
         end else if (set_count >= CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            for (i = set_count; i > pos; i--) set_entries[i] = set_entries[i-1];
            set_entries[pos] = c.address;
            set_count++;
         end
      end else if (c.op == OP_REMOVE) begin
         if (c.address == '0 || pos >= set_count || set_entries[pos] != c.address) begin
            r.status = ST_NOTFOUND;
         end else begin
            for (i = pos; i + 1 < set_count; i++) set_entries[i] = set_entries[i+1];
            set_count--;
         end
      end else if (c.op == OP_READ) begin
         if (int'(c.index) < set_count && int'(c.index) < CAPACITY) begin
            r.value = set_entries[c.index];
         end else begin
            r.status = ST_RANGE;
         end
      end
      r.total = set_count[TOTAL_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   task automatic push_cmd(logic [OP_W-1:0] op, logic [63:0] address, logic [6:0] index);
      command_type c;
      c.op      = op;
      c.address = address;
      c.index   = index;
      command_backlog.push_back(c);
   endtask

   function automatic logic [63:0] fresh_address();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 15));
      if (pick == 1) return 64'($urandom_range(1, 16));
      return {$urandom, $urandom};
   endfunction

   // draws a stored-looking address, usually taking it out of the pool
   function automatic logic [63:0] pool_address();
      int          k;
      logic [63:0] a;
      if (address_pool.size() == 0) return fresh_address();
      k = $urandom_range(0, address_pool.size() - 1);
      a = address_pool[k];
      if ($urandom_range(0, 3) != 0) address_pool.delete(k);
      return a;
   endfunction

   function automatic logic [6:0] read_index();
      int pick;
      pick = $urandom_range(0, 3);
      if (pick == 0) return 7'd127;
      if (pick == 1) return 7'($urandom_range(0, 15));
      return 7'($urandom_range(0, 127));
   endfunction

   // driver: beats change on the falling edge, valid held until taken
   always @(negedge clock) begin
      if (!reset) begin
         rsp_tready <= quiet || ($urandom_range(0, 99) >= 20);
         if (sent_count == accept_count) begin
            if (command_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= 20)) begin
               driven_cmd = command_backlog.pop_front();
               req_tdata  <= {1'b0, driven_cmd.index, driven_cmd.address};
               req_tuser  <= driven_cmd.op;
               req_tvalid <= 1'b1;
               sent_count++;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks result beats, and predicts on each accepted command beat
   always @(posedge clock) begin
      cycle_nr++;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result beat", rsp_tdata[63:0], '0);
            end else begin
               want_rsp = pending_results.pop_front();
               if (rsp_tuser != want_rsp.status)
                  report_mismatch("status", 64'(rsp_tuser), 64'(want_rsp.status));
               if (rsp_tdata[7:0] != want_rsp.total)
                  report_mismatch("entry_total", 64'(rsp_tdata[7:0]), 64'(want_rsp.total));
               if (rsp_tdata[71:8] != want_rsp.value)
                  report_mismatch("read_value", rsp_tdata[71:8], want_rsp.value);
            end
         end
         if (req_tvalid && req_tready) begin
            pending_results.push_back(apply_to_set(driven_cmd));
            accept_count++;
         end
      end
   end

   initial begin
      int          n;
      int          mode;
      int          seg_len;
      int          r;
      logic [63:0] a;

      // directed: empty-set corners, zero address, extremes, duplicate, unused op
      push_cmd(OP_READ,   {$urandom, $urandom}, 7'd0);
      push_cmd(OP_REMOVE, 64'd0, 7'd0);
      push_cmd(OP_INSERT, 64'd0, 7'd127);
      push_cmd(OP_REMOVE, 64'd5, 7'd0);
      push_cmd(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
      push_cmd(OP_INSERT, 64'd1, 7'd0);
      push_cmd(OP_INSERT, 64'd1, 7'd0);
      push_cmd(OP_INSERT, 64'h8000_0000_0000_0000, 7'd0);
      push_cmd(OP_READ,   64'd0, 7'd0);
      push_cmd(OP_READ,   64'd0, 7'd2);
      push_cmd(OP_READ,   64'd0, 7'd3);
      push_cmd(OP_READ,   64'd0, 7'd127);
      push_cmd(OP_UNUSED, {$urandom, $urandom}, 7'($urandom_range(0, 127)));
      push_cmd(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
      push_cmd(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
      push_cmd(OP_INSERT, 64'h5555_5555_5555_5555, 7'd0);
      push_cmd(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 7'd0);
      push_cmd(OP_READ,   64'd0, 7'd1);
      push_cmd(OP_READ,   64'd0, 7'd2);
      push_cmd(OP_REMOVE, 64'd1, 7'd0);
      push_cmd(OP_REMOVE, 64'h8000_0000_0000_0000, 7'd0);
      push_cmd(OP_REMOVE, 64'h5555_5555_5555_5555, 7'd0);
      push_cmd(OP_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA, 7'd0);

      // random: segments that grow, shrink or churn the set; the first one grows it
      n = 0;
      mode = 0;
      while (n < RANDOM_ITEMS) begin
         seg_len = $urandom_range(150, 250);
         for (int k = 0; k < seg_len && n < RANDOM_ITEMS; k++) begin
            r = $urandom_range(0, 99);
            if (r >= 97) begin
               // noise: unused op or zero address
               case ($urandom_range(0, 2))
                  0: push_cmd(OP_UNUSED, {$urandom, $urandom}, 7'($urandom_range(0, 127)));
                  1: push_cmd(OP_INSERT, 64'd0, 7'($urandom_range(0, 127)));
                  default: push_cmd(OP_REMOVE, 64'd0, 7'($urandom_range(0, 127)));
               endcase
            end else if ((mode == 0 && r < 75) || (mode == 1 && r < 15)
                         || (mode == 2 && r < 35)) begin
               if ($urandom_range(0, 9) == 0 && address_pool.size() != 0) begin
                  a = address_pool[$urandom_range(0, address_pool.size() - 1)];
               end else begin
                  a = fresh_address();
                  address_pool.push_back(a);
                  if (address_pool.size() > 300) address_pool.delete(0);
               end
               push_cmd(OP_INSERT, a, 7'($urandom_range(0, 127)));
            end else if ((mode == 0 && r < 85) || (mode == 1 && r < 25)
                         || (mode == 2 && r < 65)) begin
               push_cmd(OP_READ, {$urandom, $urandom}, read_index());
            end else begin
               push_cmd(OP_REMOVE, pool_address(), 7'($urandom_range(0, 127)));
            end
            n++;
         end
         mode = $urandom_range(0, 2);
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (command_backlog.size() != 0 || req_tvalid || pending_results.size() != 0)
         @(posedge clock);
      // tail: catch any stray result beat
      repeat (20) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
